[rtl/core/lrt_pkg.sv]
// Shared types, sizes and the node merge function for the longest repeat run tree.
// No dependencies; imported by the node memory, the top level and the checker.
`timescale 1ns / 1ps

package lrt_pkg;

    localparam int MAX_LENGTH  = 1024;
    localparam int STORE_DEPTH = 4 * MAX_LENGTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int POS_W       = 10;
    localparam int CHAR_W      = 8;
    localparam int RUN_W       = 11;
    localparam int LEN_W       = 11;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 16;

    localparam logic [RUN_W-1:0] RUN_CAP     = RUN_W'(2 * MAX_LENGTH - 1);
    localparam logic [LEN_W-1:0] LEN_RESET   = LEN_W'(MAX_LENGTH);
    localparam logic [POS_W-1:0] POS_MAX     = POS_W'(MAX_LENGTH - 1);
    localparam logic [ADDR_W-1:0] ROOT_NODE  = ADDR_W'(1);
    localparam logic [ADDR_W-1:0] LAST_ENTRY = ADDR_W'(STORE_DEPTH - 1);

    typedef logic [ADDR_W-1:0] addr_t;

    typedef struct packed {
        logic [CHAR_W-1:0] lch;
        logic [CHAR_W-1:0] rch;
        logic [RUN_W-1:0]  prefix;
        logic [RUN_W-1:0]  suffix;
        logic [RUN_W-1:0]  best;
        logic [RUN_W-1:0]  length;
    } node_t;

    function automatic logic [RUN_W-1:0] sat_add(input logic [RUN_W-1:0] a,
                                                 input logic [RUN_W-1:0] b);
        logic [RUN_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, RUN_CAP}) ? RUN_CAP : s[RUN_W-1:0];
    endfunction

    // Merge left node a with right node b.
    function automatic node_t join_nodes(input node_t a, input node_t b);
        node_t            r;
        logic             meet;
        logic [RUN_W-1:0] span_run;
        meet     = (a.rch == b.lch);
        span_run = sat_add(a.suffix, b.prefix);
        r.lch    = a.lch;
        r.rch    = b.rch;
        r.length = sat_add(a.length, b.length);
        r.prefix = a.prefix;
        if (meet && (a.prefix == a.length))
        begin
            r.prefix = sat_add(a.length, b.prefix);
        end
        r.suffix = b.suffix;
        if (meet && (b.suffix == b.length))
        begin
            r.suffix = sat_add(b.length, a.suffix);
        end
        r.best = (a.best > b.best) ? a.best : b.best;
        if (meet && (span_run > r.best))
        begin
            r.best = span_run;
        end
        return r;
    endfunction

endpackage

[rtl/core/lrt_node_ram.sv]
// Tree node store: one write port, one read port with registered read data.
// Depends on lrt_pkg for the node type and store depth.
`timescale 1ns / 1ps

module lrt_node_ram (
    input  logic          clk,
    input  logic          we,
    input  lrt_pkg::addr_t waddr,
    input  lrt_pkg::node_t wdata,
    input  logic          re,
    input  lrt_pkg::addr_t raddr,
    output lrt_pkg::node_t rdata
);
    import lrt_pkg::*;

    node_t mem [STORE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/core/longest_repeat_run_tree_unit.sv]
// An in-range write of tree depth d (d <= 10 at full length) descends to its
// leaf, writes the leaf, merges back up to the root one level at a time, then
// loads the output register once free; an out-of-range one returns the root best.
// The merge walk is bound by the single read port of the node memory.
// Reset: a clearing pass zeroes all 4096 nodes, one per cycle; s_tready stays low
// until the pass is done. Configuration writes are taken at any time.
// Depends on lrt_pkg and lrt_node_ram.
`timescale 1ns / 1ps

module longest_repeat_run_tree_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lrt_pkg::IN_TDATA_W-1:0]  s_tdata,   // [9:0] position, [17:10] character
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lrt_pkg::OUT_TDATA_W-1:0] m_tdata,   // [10:0] longest_run
    input  logic                            cfg_we,
    input  logic [lrt_pkg::LEN_W-1:0]       cfg_wdata  // active_length
);
    import lrt_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR   = 5'b00001,
        S_IDLE    = 5'b00010,
        S_DESCEND = 5'b00100,
        S_MERGE   = 5'b01000,
        S_DONE    = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [LEN_W-1:0]  active_length_reg;
    addr_t             clr_cnt_reg, clr_cnt_next;
    addr_t             node_reg, node_next;
    logic [POS_W-1:0]  lo_reg, lo_next;
    logic [POS_W-1:0]  hi_reg, hi_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [CHAR_W-1:0] ch_reg, ch_next;
    node_t             carry_reg, carry_next;
    logic [RUN_W-1:0]  root_best_reg, root_best_next;
    logic [RUN_W-1:0]  result_reg, result_next;
    logic              out_valid_reg, out_valid_next;
    logic [RUN_W-1:0]  out_data_reg, out_data_next;

    logic             mem_we;
    addr_t            mem_waddr;
    node_t            mem_wdata;
    logic             mem_re;
    addr_t            mem_raddr;
    node_t            mem_rdata;

    logic [POS_W-1:0] len_m1;
    logic [LEN_W-1:0] len_dec;
    logic [POS_W-1:0] in_pos;
    logic [CHAR_W-1:0] in_ch;
    logic [POS_W-1:0] mid;
    addr_t            parent;
    node_t            leaf;
    node_t            joined;

    lrt_node_ram u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign in_pos  = s_tdata[POS_W-1:0];
    assign in_ch   = s_tdata[POS_W+CHAR_W-1:POS_W];
    assign len_dec = active_length_reg - LEN_W'(1);

    // Zero length counts as one, anything above the maximum as the maximum.
    always_comb
    begin
        priority if (active_length_reg == '0)
        begin
            len_m1 = '0;
        end
        else if (active_length_reg > LEN_RESET)
        begin
            len_m1 = POS_MAX;
        end
        else
        begin
            len_m1 = len_dec[POS_W-1:0];
        end
    end

    assign mid    = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign parent = node_reg >> 1;

    always_comb
    begin
        leaf.lch    = ch_reg;
        leaf.rch    = ch_reg;
        leaf.prefix = RUN_W'(1);
        leaf.suffix = RUN_W'(1);
        leaf.best   = RUN_W'(1);
        leaf.length = RUN_W'(1);
    end

    // The carried node is the child just written; memory supplies its sibling.
    assign joined = node_reg[0] ? join_nodes(mem_rdata, carry_reg)
                                : join_nodes(carry_reg, mem_rdata);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(out_data_reg);

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        node_next      = node_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        pos_next       = pos_reg;
        ch_next        = ch_reg;
        carry_next     = carry_reg;
        root_best_next = root_best_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = node_reg;
        mem_wdata      = leaf;
        mem_re         = 1'b0;
        mem_raddr      = node_reg ^ ADDR_W'(1);

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == LAST_ENTRY)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    pos_next = in_pos;
                    ch_next  = in_ch;
                    if (in_pos > len_m1)
                    begin
                        result_next = root_best_reg;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        node_next  = ROOT_NODE;
                        lo_next    = '0;
                        hi_next    = len_m1;
                        state_next = S_DESCEND;
                    end
                end
            end
            S_DESCEND:
            begin
                if (lo_reg == hi_reg)
                begin
                    // Write the leaf, then fetch its sibling for the first merge.
                    mem_we     = 1'b1;
                    carry_next = leaf;
                    if (node_reg == ROOT_NODE)
                    begin
                        root_best_next = leaf.best;
                        result_next    = leaf.best;
                        state_next     = S_DONE;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        state_next = S_MERGE;
                    end
                end
                else if (pos_reg <= mid)
                begin
                    node_next = {node_reg[ADDR_W-2:0], 1'b0};
                    hi_next   = mid;
                end
                else
                begin
                    node_next = {node_reg[ADDR_W-2:0], 1'b1};
                    lo_next   = mid + POS_W'(1);
                end
            end
            S_MERGE:
            begin
                mem_we     = 1'b1;
                mem_waddr  = parent;
                mem_wdata  = joined;
                carry_next = joined;
                node_next  = parent;
                if (parent == ROOT_NODE)
                begin
                    root_best_next = joined.best;
                    result_next    = joined.best;
                    state_next     = S_DONE;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = parent ^ ADDR_W'(1);
                end
            end
            S_DONE:
            begin
                // Hold the result until the output register frees up.
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = result_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_CLEAR;
            clr_cnt_reg       <= '0;
            root_best_reg     <= '0;
            out_valid_reg     <= 1'b0;
            active_length_reg <= LEN_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            root_best_reg <= root_best_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                active_length_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg     <= node_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        pos_reg      <= pos_next;
        ch_reg       <= ch_next;
        carry_reg    <= carry_next;
        result_reg   <= result_next;
        out_data_reg <= out_data_next;
    end

endmodule

[rtl/core/lrt_checker.sv]
// Port-level checks for longest_repeat_run_tree_unit, attached by bind.
// Depends on lrt_pkg for the stream widths.
`timescale 1ns / 1ps

module lrt_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [lrt_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import lrt_pkg::*;

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    // One item at a time: busy right after an accept.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after an accept");

    // A new result comes only out of a busy cycle.
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared without work");

    // Padding above the run length stays zero.
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[OUT_TDATA_W-1:RUN_W] == '0))
        else $error("nonzero padding in result");

endmodule

bind longest_repeat_run_tree_unit lrt_checker u_lrt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
